// ----- design/i2cbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Types, command codes and the microcode program of the I2C bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int unsigned PhaseW = 16;
  localparam int unsigned UpcW   = 5;

  typedef logic [UpcW-1:0] upc_t;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_SEND_ACK = 3'd4,
    CMD_RECV_ACK = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    SCL_KEEP,
    SCL_LO,
    SCL_HI
  } scl_op_t;

  typedef enum logic [2:0] {
    SDA_KEEP,
    SDA_LO,
    SDA_HI,
    SDA_ACK,
    SDA_SHIFT
  } sda_op_t;

  typedef enum logic [1:0] {
    FLOW_NEXT,
    FLOW_END,
    FLOW_LOOP
  } flow_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EMIT,
    SEQ_HOLD
  } seq_state_t;

  typedef struct packed {
    scl_op_t scl_op;
    sda_op_t sda_op;
    logic    sample;
    logic    rbyte_out;
    logic    ack_out;
    flow_t   flow;
    upc_t    target;
  } ucode_t;

  // one phase step handed from the sequencer to the datapath
  typedef struct packed {
    logic       fire;
    ucode_t     word;
    logic [2:0] bit_index;
    logic       last;
  } step_t;

  localparam upc_t PC_START    = 5'd0;
  localparam upc_t PC_STOP     = 5'd4;
  localparam upc_t PC_WRITE    = 5'd7;
  localparam upc_t PC_READ     = 5'd10;
  localparam upc_t PC_READ_BIT = 5'd11;
  localparam upc_t PC_SEND_ACK = 5'd14;
  localparam upc_t PC_RECV_ACK = 5'd17;

  function automatic ucode_t mk(scl_op_t scl_op, sda_op_t sda_op, logic sample,
                                logic rbyte_out, logic ack_out, flow_t flow,
                                upc_t target);
    ucode_t w;
    w.scl_op    = scl_op;
    w.sda_op    = sda_op;
    w.sample    = sample;
    w.rbyte_out = rbyte_out;
    w.ack_out   = ack_out;
    w.flow      = flow;
    w.target    = target;
    return w;
  endfunction

  function automatic upc_t entry_pc(logic [2:0] cmd);
    upc_t pc;
    case (cmd)
      CMD_START:    pc = PC_START;
      CMD_STOP:     pc = PC_STOP;
      CMD_WRITE:    pc = PC_WRITE;
      CMD_READ:     pc = PC_READ;
      CMD_SEND_ACK: pc = PC_SEND_ACK;
      CMD_RECV_ACK: pc = PC_RECV_ACK;
      default:      pc = PC_START;
    endcase
    return pc;
  endfunction

  // control store, one word per pin phase
  function automatic ucode_t ucode(upc_t pc);
    ucode_t w;
    case (pc)
      // start
      5'd0:  w = mk(SCL_KEEP, SDA_HI,    1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd1:  w = mk(SCL_HI,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd2:  w = mk(SCL_KEEP, SDA_LO,    1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd3:  w = mk(SCL_LO,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_END,  PC_START);
      // stop
      5'd4:  w = mk(SCL_KEEP, SDA_LO,    1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd5:  w = mk(SCL_HI,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd6:  w = mk(SCL_KEEP, SDA_HI,    1'b0, 1'b0, 1'b0, FLOW_END,  PC_START);
      // write byte, msb first
      5'd7:  w = mk(SCL_KEEP, SDA_SHIFT, 1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd8:  w = mk(SCL_HI,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd9:  w = mk(SCL_LO,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_LOOP, PC_WRITE);
      // read byte
      5'd10: w = mk(SCL_KEEP, SDA_HI,    1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd11: w = mk(SCL_HI,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd12: w = mk(SCL_KEEP, SDA_KEEP,  1'b1, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd13: w = mk(SCL_LO,   SDA_KEEP,  1'b0, 1'b1, 1'b0, FLOW_LOOP, PC_READ_BIT);
      // send ack
      5'd14: w = mk(SCL_KEEP, SDA_ACK,   1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd15: w = mk(SCL_HI,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd16: w = mk(SCL_LO,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_END,  PC_START);
      // receive ack
      5'd17: w = mk(SCL_KEEP, SDA_HI,    1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd18: w = mk(SCL_HI,   SDA_KEEP,  1'b0, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd19: w = mk(SCL_KEEP, SDA_KEEP,  1'b1, 1'b0, 1'b0, FLOW_NEXT, PC_START);
      5'd20: w = mk(SCL_LO,   SDA_KEEP,  1'b0, 1'b0, 1'b1, FLOW_END,  PC_START);
      default: w = mk(SCL_KEEP, SDA_KEEP, 1'b0, 1'b0, 1'b0, FLOW_END, PC_START);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- design/i2cbs_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbs_sequencer
// Microprogram counter, bit loop counter and phase hold timer.
// ----------------------------------------------------------------------------
module i2cbs_sequencer (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cmd_valid,
  input  wire  [2:0]                   cmd,
  output logic                         cmd_ready,
  input  wire                          cfg_valid,
  input  wire  [i2cbs_pkg::PhaseW-1:0] cfg_data,
  output logic                         cfg_ready,
  input  wire                          out_free,
  output i2cbs_pkg::step_t             step
);

  i2cbs_pkg::seq_state_t           state_r, state_nxt;
  i2cbs_pkg::upc_t                 pc_r, pc_nxt;
  logic [2:0]                      bit_r, bit_nxt;
  logic [i2cbs_pkg::PhaseW-1:0]    timer_r, timer_nxt;
  logic                            done_r, done_nxt;
  logic [i2cbs_pkg::PhaseW-1:0]    plen_r;
  i2cbs_pkg::ucode_t               word;
  logic                            last;
  logic                            fire;

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state_r == i2cbs_pkg::SEQ_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2cbs_pkg::SEQ_IDLE;
      pc_r    <= '0;
      bit_r   <= '0;
      timer_r <= '0;
      done_r  <= 1'b0;
      plen_r  <= i2cbs_pkg::PhaseW'(10);
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      bit_r   <= bit_nxt;
      timer_r <= timer_nxt;
      done_r  <= done_nxt;
      if (cfg_valid) begin
        plen_r <= cfg_data;
      end
    end
  end

  always_comb begin
    word      = i2cbs_pkg::ucode(pc_r);
    last      = (word.flow == i2cbs_pkg::FLOW_END) ||
                ((word.flow == i2cbs_pkg::FLOW_LOOP) && (bit_r == 3'd7));
    fire      = 1'b0;
    state_nxt = state_r;
    pc_nxt    = pc_r;
    bit_nxt   = bit_r;
    timer_nxt = timer_r;
    done_nxt  = done_r;
    case (state_r)
      i2cbs_pkg::SEQ_IDLE: begin
        // unused command codes are taken and dropped
        if (cmd_valid && (cmd <= i2cbs_pkg::CMD_RECV_ACK)) begin
          pc_nxt    = i2cbs_pkg::entry_pc(cmd);
          bit_nxt   = 3'd0;
          state_nxt = i2cbs_pkg::SEQ_EMIT;
        end
      end
      i2cbs_pkg::SEQ_EMIT: begin
        if (out_free) begin
          fire      = 1'b1;
          done_nxt  = last;
          timer_nxt = (plen_r == '0) ? '0 : plen_r - 1'b1;
          state_nxt = i2cbs_pkg::SEQ_HOLD;
          if ((word.flow == i2cbs_pkg::FLOW_LOOP) && !last) begin
            pc_nxt  = word.target;
            bit_nxt = bit_r + 3'd1;
          end else if (word.flow == i2cbs_pkg::FLOW_NEXT) begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      i2cbs_pkg::SEQ_HOLD: begin
        if (timer_r == '0) begin
          state_nxt = done_r ? i2cbs_pkg::SEQ_IDLE : i2cbs_pkg::SEQ_EMIT;
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      default: begin
        state_nxt = i2cbs_pkg::SEQ_IDLE;
      end
    endcase
    step.fire      = fire;
    step.word      = word;
    step.bit_index = bit_r;
    step.last      = last;
  end

endmodule
`default_nettype wire

// ----- design/i2cbs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbs_datapath
// Pin level holds, shift byte and the registered result beat.
// ----------------------------------------------------------------------------
module i2cbs_datapath (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cmd_accept,
  input  wire  [2:0]             cmd,
  input  wire  [7:0]             write_byte,
  input  wire                    ack_to_send,
  input  wire  [7:0]             sda_seen,
  input  i2cbs_pkg::step_t       step,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_scl,
  output logic                   out_sda,
  output logic                   out_sample,
  output logic [7:0]             out_rbyte,
  output logic                   out_ack,
  output logic                   out_last
);

  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       ack_r;
  logic [7:0] seen_r;
  logic       valid_r;
  logic       oscl_r, osda_r, osample_r, oack_r, olast_r;
  logic [7:0] orbyte_r;
  logic [2:0] msb_idx;

  assign out_free   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_scl    = oscl_r;
  assign out_sda    = osda_r;
  assign out_sample = osample_r;
  assign out_rbyte  = orbyte_r;
  assign out_ack    = oack_r;
  assign out_last   = olast_r;

  always_comb begin
    msb_idx   = 3'd7 - step.bit_index;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    shift_nxt = shift_r;
    case (step.word.scl_op)
      i2cbs_pkg::SCL_LO: scl_nxt = 1'b0;
      i2cbs_pkg::SCL_HI: scl_nxt = 1'b1;
      default:           scl_nxt = scl_r;
    endcase
    case (step.word.sda_op)
      i2cbs_pkg::SDA_LO:    sda_nxt = 1'b0;
      i2cbs_pkg::SDA_HI:    sda_nxt = 1'b1;
      i2cbs_pkg::SDA_ACK:   sda_nxt = ack_r;
      i2cbs_pkg::SDA_SHIFT: sda_nxt = shift_r[msb_idx];
      default:              sda_nxt = sda_r;
    endcase
    if (step.word.sample && seen_r[msb_idx]) begin
      shift_nxt[msb_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      shift_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cmd_accept) begin
        if (cmd == i2cbs_pkg::CMD_WRITE) begin
          shift_r <= write_byte;
        end else if (cmd == i2cbs_pkg::CMD_READ) begin
          shift_r <= '0;
        end
      end else if (step.fire) begin
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        shift_r <= shift_nxt;
      end
      if (step.fire) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      ack_r  <= ack_to_send;
      seen_r <= sda_seen;
    end
    if (step.fire) begin
      oscl_r    <= scl_nxt;
      osda_r    <= sda_nxt;
      osample_r <= step.word.sample;
      // the byte only shows on the final bit of the read
      orbyte_r  <= (step.word.rbyte_out && step.last) ? shift_nxt : 8'h00;
      oack_r    <= step.word.ack_out & seen_r[7];
      olast_r   <= step.last;
    end
  end

endmodule
`default_nettype wire

// ----- design/i2c_master_bit_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Expands I2C master commands into pin phases from a microcoded control store.
// ----------------------------------------------------------------------------
// each pin phase, once the output is free, has an emit state to step the microcode
// and load the beat, then a hold state that counts down the phase_length timer
// a command takes 3 to 25 phases
// one command at a time, the next is taken from the cycle after the last phase hold
// the first beat is emitted from the emit state and registered as the output beat
// synchronous reset: lines released, phase_length 10, no beat pending
module i2c_master_bit_sequencer (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [23:0]  in_tdata,   // write_byte[7:0], ack_to_send[8], sda_seen[16:9]
  input  wire  [2:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [15:0]  out_tdata,  // scl_level[0], sda_level[1], read_byte[9:2], ack_seen[10]
  output logic         out_tuser,  // sample_point
  output logic         out_tlast,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [15:0]  cfg_data
);

  i2cbs_pkg::step_t step;
  logic             out_free;
  logic             in_accept;
  logic             o_scl, o_sda, o_ack;
  logic [7:0]       o_rbyte;

  assign in_accept = in_tvalid && in_tready;
  assign out_tdata = {5'b0, o_ack, o_rbyte, o_sda, o_scl};

  i2cbs_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd       (in_tuser),
    .cmd_ready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .out_free  (out_free),
    .step      (step)
  );

  i2cbs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_accept  (in_accept),
    .cmd         (in_tuser),
    .write_byte  (in_tdata[7:0]),
    .ack_to_send (in_tdata[8]),
    .sda_seen    (in_tdata[16:9]),
    .step        (step),
    .out_free    (out_free),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_scl     (o_scl),
    .out_sda     (o_sda),
    .out_sample  (out_tuser),
    .out_rbyte   (o_rbyte),
    .out_ack     (o_ack),
    .out_last    (out_tlast)
  );

endmodule
`default_nettype wire
